// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL file that carries checks, the core top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/itoar_pkg.sv
// ----------------------------------------------------------------------------
// itoar_pkg
// Shared types, constants and helpers for the integer to ASCII radix core.
// ----------------------------------------------------------------------------
package itoar_pkg;

    localparam int WORD_BITS_DEFAULT = 32;
    localparam int IN_WORD_BITS      = 32;
    localparam int RADIX_BITS        = 6;
    localparam int CHAR_BITS         = 8;
    localparam int DIV_STEP_BITS     = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_DECIMAL = 6'd10;
    localparam logic [RADIX_BITS-1:0] DIGIT_MAX_NUM = 6'd9;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT,
        S_BAD
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic load_sign;
        logic rd_issue;
        logic load_digit;
        logic load_bad;
    } ctrl_cmd_t;

    typedef struct packed {
        logic radix_bad;
        logic div_last;
        logic quot_zero;
        logic neg;
        logic idx_zero;
        logic out_free;
    } dp_status_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d > DIGIT_MAX_NUM)
        begin
            c = CHAR_LOW_A + CHAR_BITS'(d) - CHAR_BITS'(DIGIT_MAX_NUM + 6'd1);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        return c;
    endfunction

endpackage

// File: rtl/itoar_ctrl.sv
// ----------------------------------------------------------------------------
// itoar_ctrl
// Sequencer: request intake, division loop, sign and digit emission, bad-radix result.
// ----------------------------------------------------------------------------
module itoar_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  itoar_pkg::dp_status_t  status,
    output itoar_pkg::ctrl_cmd_t   cmd
);
    import itoar_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.radix_bad ? S_BAD : S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_last && status.quot_zero)
                begin
                    state_next = status.neg ? S_SIGN : S_READ;
                end
            end
            S_SIGN:
            begin
                if (status.out_free)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.idx_zero ? S_IDLE : S_READ;
                end
            end
            S_BAD:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_SIGN:
            begin
                cmd.load_sign = status.out_free;
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            S_EMIT:
            begin
                cmd.load_digit = status.out_free;
            end
            S_BAD:
            begin
                cmd.load_bad = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/itoar_datapath.sv
// ----------------------------------------------------------------------------
// itoar_datapath
// Operand capture, 8-bit-per-cycle radix divider, digit store, output register.
// ----------------------------------------------------------------------------
module itoar_datapath #(
    parameter int WORD_BITS = itoar_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [itoar_pkg::IN_WORD_BITS-1:0]    value_word,
    input  logic [itoar_pkg::RADIX_BITS-1:0]      radix,
    input  itoar_pkg::ctrl_cmd_t                  cmd,
    output itoar_pkg::dp_status_t                 status,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [itoar_pkg::CHAR_BITS-1:0]       char_code,
    output logic                                  last_char,
    output logic                                  bad_radix
);
    import itoar_pkg::*;

    localparam int DIV_CYCLES = (WORD_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int PAD_BITS   = DIV_CYCLES * DIV_STEP_BITS;
    localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int IDX_W      = $clog2(WORD_BITS);

    logic [PAD_BITS-1:0]      word_reg;
    logic [RADIX_BITS-1:0]    radix_reg;
    logic                     neg_reg;
    logic [RADIX_BITS-1:0]    rem_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [IDX_W-1:0]         wr_ptr_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [RADIX_BITS-1:0]    rd_data_reg;
    logic                     out_valid_reg;
    logic [CHAR_BITS-1:0]     char_reg;
    logic                     last_reg;
    logic                     bad_reg;

    logic [RADIX_BITS-1:0]    digit_mem [WORD_BITS];

    logic [WORD_BITS-1:0]     in_word;
    logic                     in_neg;
    logic [WORD_BITS-1:0]     in_mag;
    logic [DIV_STEP_BITS-1:0] top_bits;
    logic [DIV_STEP_BITS-1:0] q_bits;
    logic [RADIX_BITS-1:0]    rem_new;
    logic [RADIX_BITS:0]      trial;
    logic [PAD_BITS+DIV_STEP_BITS-1:0] shifted;
    logic [PAD_BITS-1:0]      word_div;
    logic                     div_last;
    logic                     out_free;

    always_comb
    begin
        in_word = WORD_BITS'(value_word);
        in_neg  = (radix == RADIX_DECIMAL) && in_word[WORD_BITS-1];
        in_mag  = in_neg ? (~in_word + WORD_BITS'(1)) : in_word;
    end

    // restoring division, one quotient byte per cycle, remainder stays below radix
    always_comb
    begin
        top_bits = word_reg[PAD_BITS-1 -: DIV_STEP_BITS];
        rem_new  = rem_reg;
        q_bits   = '0;
        trial    = '0;
        for (int i = DIV_STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {rem_new, top_bits[i]};
            if (trial >= {1'b0, radix_reg})
            begin
                q_bits[i] = 1'b1;
                rem_new   = RADIX_BITS'(trial - {1'b0, radix_reg});
            end
            else
            begin
                rem_new = trial[RADIX_BITS-1:0];
            end
        end
        shifted  = {word_reg, q_bits};
        word_div = shifted[PAD_BITS-1:0];
    end

    assign div_last = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
        status.div_last  = div_last;
        status.quot_zero = (word_div == '0);
        status.neg       = neg_reg;
        status.idx_zero  = (idx_reg == '0);
        status.out_free  = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg   <= '0;
                wr_ptr_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= div_last ? '0 : step_reg + STEP_W'(1);
                if (div_last)
                begin
                    wr_ptr_reg <= wr_ptr_reg + IDX_W'(1);
                end
            end
            if (cmd.load_sign || cmd.load_digit || cmd.load_bad)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg  <= PAD_BITS'(in_mag);
            radix_reg <= radix;
            neg_reg   <= in_neg;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            word_reg <= word_div;
            rem_reg  <= div_last ? '0 : rem_new;
            if (div_last)
            begin
                digit_mem[wr_ptr_reg] <= rem_new;
                idx_reg               <= wr_ptr_reg;
            end
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= digit_mem[idx_reg];
        end
        if (cmd.load_digit)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
        if (cmd.load_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
            bad_reg  <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            char_reg <= digit_char(rd_data_reg);
            last_reg <= (idx_reg == '0);
            bad_reg  <= 1'b0;
        end
        else if (cmd.load_bad)
        begin
            char_reg <= CHAR_NONE;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign bad_radix = bad_reg;

endmodule

// File: rtl/integer_to_ascii_radix_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Integer word to ASCII text in radix 2..36, most significant digit first.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Fields
//  --------+---------------------+-------------------------------------
//  in      | in_valid / in_stall | value_word[31:0], radix[5:0]
//  out     | out_valid/out_stall | char_code[7:0], last_char, bad_radix
//
//  A request divides once per digit, emits a minus sign if negative, then
//  reads and emits each digit; the divider retires eight quotient bits a
//  cycle. Bad radix: one result. Reset is asynchronous, active low, and
//  leaves the core idle. Output stalls hold the sequencer; a new request is
//  taken while the final character still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_ascii_radix_core #(
    parameter int WORD_BITS = itoar_pkg::WORD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [itoar_pkg::IN_WORD_BITS-1:0] value_word,
    input  logic [itoar_pkg::RADIX_BITS-1:0]   radix,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [itoar_pkg::CHAR_BITS-1:0]    char_code,
    output logic                               last_char,
    output logic                               bad_radix
);
    import itoar_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    itoar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    itoar_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_word (value_word),
        .radix      (radix),
        .cmd        (cmd),
        .status     (status),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .char_code  (char_code),
        .last_char  (last_char),
        .bad_radix  (bad_radix)
    );

    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "request not held off")
    `ASSERT_IMPLIES(a_bad_is_last, clk, rst_n, out_valid && bad_radix, last_char && (char_code == CHAR_NONE), "bad radix result malformed")
    `ASSERT_IMPLIES(a_mid_text_busy, clk, rst_n, out_valid && !last_char, in_stall, "request taken mid text")

endmodule

// File: bench/tb_integer_to_ascii_radix_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_core
// Self-checking bench for the integer to ASCII radix core. Requests of one
// word and one radix are driven with random gaps. The scoreboard spells each
// accepted request into its expected characters, and every character taken
// from the output is compared field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_core;
    import itoar_pkg::*;

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
        logic                 bad;
    } text_char_t;

    class char_scoreboard;
        text_char_t expected_chars[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        // spells one accepted request into the characters it must produce
        function void note_request(logic [IN_WORD_BITS-1:0] value, logic [RADIX_BITS-1:0] base);
            logic [RADIX_BITS-1:0]   digit_buf [WORD_BITS_DEFAULT];
            logic [IN_WORD_BITS-1:0] magnitude;
            logic [CHAR_BITS-1:0]    ch;
            logic                    negative;
            int                      count;
            if (base < RADIX_MIN || base > RADIX_MAX)
            begin
                expected_chars.push_back('{code: CHAR_NONE, last: 1'b1, bad: 1'b1});
                return;
            end
            negative  = (base == RADIX_DECIMAL) && value[IN_WORD_BITS-1];
            magnitude = negative ? (~value + 1'b1) : value;
            count     = 0;
            do
            begin
                digit_buf[count] = RADIX_BITS'(magnitude % base);
                magnitude        = magnitude / base;
                count++;
            end
            while (magnitude != 0 && count < WORD_BITS_DEFAULT);
            if (negative)
            begin
                expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0, bad: 1'b0});
            end
            for (int i = count - 1; i >= 0; i--)
            begin
                if (digit_buf[i] > DIGIT_MAX_NUM)
                begin
                    ch = CHAR_LOW_A + CHAR_BITS'(digit_buf[i]) - 8'd10;
                end
                else
                begin
                    ch = CHAR_ZERO + CHAR_BITS'(digit_buf[i]);
                end
                expected_chars.push_back('{code: ch, last: (i == 0), bad: 1'b0});
            end
        endfunction

        function void check_char(logic [CHAR_BITS-1:0] code, logic last, logic bad);
            text_char_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected char: char_code=%h last_char=%b bad_radix=%b",
                         $time, code, last, bad);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: char_code expected %h actual %h", $time, want.code, code);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_char expected %b actual %b", $time, want.last, last);
                mismatches++;
            end
            if (bad !== want.bad)
            begin
                $display("%0t: bad_radix expected %b actual %b", $time, want.bad, bad);
                mismatches++;
            end
        endfunction
    endclass

    localparam int DIRECTED_COUNT = 20;
    localparam int RANDOM_PER_PHASE = 120;

    localparam logic [IN_WORD_BITS-1:0] DIR_VALUES [DIRECTED_COUNT] = '{
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd12345,
        32'd35,        32'd9,         32'h0000_01FF, 32'hDEAD_BEEF, 32'hFFFF_CFC7,
        32'hABCD_EF12, 32'd5,         32'd5,         32'd5,         32'd5
    };
    localparam logic [RADIX_BITS-1:0] DIR_RADIXES [DIRECTED_COUNT] = '{
        6'd10, 6'd2,  6'd2,  6'd16, 6'd10,
        6'd36, 6'd10, 6'd10, 6'd16, 6'd36,
        6'd36, 6'd10, 6'd8,  6'd3,  6'd10,
        6'd35, 6'd0,  6'd1,  6'd37, 6'd63
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [IN_WORD_BITS-1:0] value_word;
    logic [RADIX_BITS-1:0]   radix;
    logic                    out_valid;
    logic                    out_stall;
    logic [CHAR_BITS-1:0]    char_code;
    logic                    last_char;
    logic                    bad_radix;

    int             in_idle_pct  = 0;
    int             out_idle_pct = 0;
    char_scoreboard sb = new();

    integer_to_ascii_radix_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_word (value_word),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .bad_radix  (bad_radix)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_500_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_char(char_code, last_char, bad_radix);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [IN_WORD_BITS-1:0] v, input logic [RADIX_BITS-1:0] r);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        value_word <= v;
        radix      <= r;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(v, r);
        @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [IN_WORD_BITS-1:0] v;
        logic [RADIX_BITS-1:0]   r;
        int                      pick;
        case ($urandom_range(3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 999);
            2:       v = $urandom >> $urandom_range(31);
            default: v = ~($urandom >> $urandom_range(31));
        endcase
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            r = RADIX_BITS'($urandom_range(0, 1));
        end
        else if (pick < 14)
        begin
            r = RADIX_BITS'($urandom_range(37, 63));
        end
        else if (pick < 40)
        begin
            r = RADIX_DECIMAL;
        end
        else if (pick < 50)
        begin
            r = $urandom_range(0, 1) ? 6'd16 : RADIX_MIN;
        end
        else
        begin
            r = RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
        end
        send_request(v, r);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        value_word <= '0;
        radix      <= '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin in_idle_pct = 24; out_idle_pct = 71; end
                1:       begin in_idle_pct = 71; out_idle_pct = 24; end
                default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
            endcase
            if (phase == 0)
            begin
                for (int i = 0; i < DIRECTED_COUNT; i++)
                begin
                    send_request(DIR_VALUES[i], DIR_RADIXES[i]);
                end
            end
            repeat (RANDOM_PER_PHASE) send_random_request();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        // room for a stray character from the longest request
        repeat (250) @(posedge clk);

        if (sb.mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/itoar_pkg.sv
rtl/itoar_ctrl.sv
rtl/itoar_datapath.sv
rtl/integer_to_ascii_radix_core.sv
bench/tb_integer_to_ascii_radix_core.sv
